[hdl/mcq_pkg.sv]
// Shared constants, types and float helpers for the Morton code quantizer.
package mcq_pkg;

	localparam int FLT_W          = 32;
	localparam int EXP_W          = 8;
	localparam int MANT_W         = 24;
	localparam int BIG_W          = MANT_W + 254;
	localparam int CODE_W         = 63;
	localparam int NUM_AXES       = 3;
	localparam int COORD_BITS_DEF = 21;
	localparam int CFG_IDX_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_LOWER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_Z = 3'd5;

	localparam logic [FLT_W-1:0] LOWER_RST = 32'h0000_0000;
	localparam logic [FLT_W-1:0] UPPER_RST = 32'h3F80_0000;

	typedef struct packed {
		logic force_zero;
		logic force_max;
	} axis_flags_t;

	function automatic logic f_nan(input logic [FLT_W-1:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	function automatic logic f_inf(input logic [FLT_W-1:0] b);
		return b[30:0] == 31'h7F80_0000;
	endfunction

	// monotone unsigned order key, both zeros alike
	function automatic logic [FLT_W-1:0] f_key(input logic [FLT_W-1:0] b);
		logic [FLT_W-1:0] v;
		v = (b[30:0] == 31'd0) ? '0 : b;
		return v[31] ? ~v : {1'b1, v[30:0]};
	endfunction

	function automatic logic [EXP_W-1:0] f_expi(input logic [FLT_W-1:0] b);
		return (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
	endfunction

	function automatic logic [MANT_W-1:0] f_mant(input logic [FLT_W-1:0] b);
		return {(b[30:23] != 8'd0), b[22:0]};
	endfunction

endpackage

[hdl/mcq_in_if.sv]
// Point channel: three float32 coordinates with valid/ready.
interface mcq_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] coord_x;
	logic [31:0] coord_y;
	logic [31:0] coord_z;

	modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
	modport sink   (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

[hdl/mcq_out_if.sv]
// Code channel: one 63-bit Morton code with valid/ready.
interface mcq_out_if;
	logic        valid;
	logic        ready;
	logic [62:0] zcode;

	modport source (output valid, output zcode, input ready);
	modport sink   (input valid, input zcode, output ready);
endinterface

[hdl/mcq_axis_prep.sv]
// Per-axis front end: classify, align to a common exponent, differences, scale by 2**COORD_BITS - 1.
module mcq_axis_prep
	import mcq_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [FLT_W-1:0]             coord,
	input  logic [FLT_W-1:0]             lower,
	input  logic [FLT_W-1:0]             upper,
	output logic [BIG_W+COORD_BITS-1:0]  num,
	output logic [BIG_W-1:0]             den,
	output axis_flags_t                  flags
);

	localparam int WN = BIG_W + COORD_BITS;

	logic [FLT_W-1:0] kp, kl, ku;
	logic [EXP_W-1:0] ep, el, eh, mn;
	logic             zero_c;

	logic [MANT_W-1:0] mp_s1, ml_s1, mu_s1;
	logic [EXP_W-1:0]  sp_s1, sl_s1, su_s1;
	logic              np_s1, nl_s1, nu_s1;
	axis_flags_t       fl_s1;

	logic [BIG_W-1:0]  p_s2, l_s2, u_s2;
	logic              np_s2, nl_s2, nu_s2;
	axis_flags_t       fl_s2;

	logic [BIG_W-1:0]  a_s3, b_s3;
	axis_flags_t       fl_s3;

	logic [WN-1:0]     n_s4;
	logic [BIG_W-1:0]  b_s4;
	axis_flags_t       fl_s4;

	always_comb begin
		kp = f_key(coord);
		kl = f_key(lower);
		ku = f_key(upper);
		ep = f_expi(coord);
		el = f_expi(lower);
		eh = f_expi(upper);
		mn = ep;
		if (el < mn) mn = el;
		if (eh < mn) mn = eh;
		zero_c = f_nan(coord) || f_nan(lower) || f_nan(upper) || f_inf(lower)
			|| f_inf(upper) || (ku <= kl) || (kp <= kl);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s1            <= f_mant(coord);
			ml_s1            <= f_mant(lower);
			mu_s1            <= f_mant(upper);
			sp_s1            <= ep - mn;
			sl_s1            <= el - mn;
			su_s1            <= eh - mn;
			np_s1            <= coord[FLT_W-1];
			nl_s1            <= lower[FLT_W-1];
			nu_s1            <= upper[FLT_W-1];
			fl_s1.force_zero <= zero_c;
			fl_s1.force_max  <= !zero_c && (kp >= ku);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2  <= {{(BIG_W-MANT_W){1'b0}}, mp_s1} << sp_s1;
			l_s2  <= {{(BIG_W-MANT_W){1'b0}}, ml_s1} << sl_s1;
			u_s2  <= {{(BIG_W-MANT_W){1'b0}}, mu_s1} << su_s1;
			np_s2 <= np_s1;
			nl_s2 <= nl_s1;
			nu_s2 <= nu_s1;
			fl_s2 <= fl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (np_s2 != nl_s2) a_s3 <= p_s2 + l_s2;
			else if (np_s2)     a_s3 <= l_s2 - p_s2;
			else                a_s3 <= p_s2 - l_s2;
			if (nu_s2 != nl_s2) b_s3 <= u_s2 + l_s2;
			else if (nu_s2)     b_s3 <= l_s2 - u_s2;
			else                b_s3 <= u_s2 - l_s2;
			fl_s3 <= fl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s4  <= ({{COORD_BITS{1'b0}}, a_s3} << COORD_BITS) - {{COORD_BITS{1'b0}}, a_s3};
			b_s4  <= b_s3;
			fl_s4 <= fl_s3;
		end
	end

	assign num   = n_s4;
	assign den   = b_s4;
	assign flags = fl_s4;

endmodule

[hdl/mcq_div_step.sv]
// One restoring division step: decide quotient bit K.
module mcq_div_step
	import mcq_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int K          = 0
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [BIG_W+COORD_BITS-1:0]  rem_in,
	input  logic [BIG_W-1:0]             den_in,
	input  logic [COORD_BITS-1:0]        quo_in,
	input  axis_flags_t                  flags_in,
	output logic [BIG_W+COORD_BITS-1:0]  rem_out,
	output logic [BIG_W-1:0]             den_out,
	output logic [COORD_BITS-1:0]        quo_out,
	output axis_flags_t                  flags_out
);

	localparam int WN = BIG_W + COORD_BITS;

	logic [WN-1:0] trial;
	logic          ge;

	logic [WN-1:0]         rem_s;
	logic [BIG_W-1:0]      den_s;
	logic [COORD_BITS-1:0] quo_s;
	axis_flags_t           fl_s;

	assign trial = {{COORD_BITS{1'b0}}, den_in} << K;
	assign ge    = rem_in >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s    <= ge ? (rem_in - trial) : rem_in;
			den_s    <= den_in;
			quo_s    <= quo_in | ({{(COORD_BITS-1){1'b0}}, ge} << K);
			fl_s     <= flags_in;
		end
	end

	assign rem_out   = rem_s;
	assign den_out   = den_s;
	assign quo_out   = quo_s;
	assign flags_out = fl_s;

endmodule

[hdl/morton_code_3d_quantizer_core.sv]
// Throughput: one point per cycle while the output buffer is not full.
// Pipeline: four front-end stages, one stage per quotient bit.
// A two-entry output buffer keeps the pipeline moving while a finished code waits.
// Reset: bounds return to lower 0.0 and upper 1.0, the pipeline and buffer empty.
// Top level of the 3D Morton code quantizer.
module morton_code_3d_quantizer_core
	import mcq_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [FLT_W-1:0]     cfg_data,
	mcq_in_if.sink               in_ch,
	mcq_out_if.source            out_ch
);

	localparam int WN  = BIG_W + COORD_BITS;
	localparam int LAT = 4 + COORD_BITS;

	logic [FLT_W-1:0] lower_q [NUM_AXES];
	logic [FLT_W-1:0] upper_q [NUM_AXES];
	logic [FLT_W-1:0] coord_v [NUM_AXES];

	logic [WN-1:0]         rem_c [NUM_AXES][COORD_BITS+1];
	logic [BIG_W-1:0]      den_c [NUM_AXES][COORD_BITS+1];
	logic [COORD_BITS-1:0] quo_c [NUM_AXES][COORD_BITS+1];
	axis_flags_t           fl_c  [NUM_AXES][COORD_BITS+1];

	logic [COORD_BITS-1:0] axis_val [NUM_AXES];
	logic [CODE_W-1:0]     code_c;

	logic [LAT-1:0]    vld_q;
	logic              out_vld_q;
	logic              skid_vld_q;
	logic [CODE_W-1:0] out_q;
	logic [CODE_W-1:0] skid_q;
	logic              en;
	logic              new_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q[0] <= LOWER_RST;
			lower_q[1] <= LOWER_RST;
			lower_q[2] <= LOWER_RST;
			upper_q[0] <= UPPER_RST;
			upper_q[1] <= UPPER_RST;
			upper_q[2] <= UPPER_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LOWER_X: lower_q[0] <= cfg_data;
				REG_LOWER_Y: lower_q[1] <= cfg_data;
				REG_LOWER_Z: lower_q[2] <= cfg_data;
				REG_UPPER_X: upper_q[0] <= cfg_data;
				REG_UPPER_Y: upper_q[1] <= cfg_data;
				REG_UPPER_Z: upper_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en          = !skid_vld_q;
	assign in_ch.ready = en;
	assign new_item    = en && vld_q[LAT-1];

	assign coord_v[0] = in_ch.coord_x;
	assign coord_v[1] = in_ch.coord_y;
	assign coord_v[2] = in_ch.coord_z;

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		mcq_axis_prep #(.COORD_BITS(COORD_BITS)) u_prep (
			.clk   (clk),
			.en    (en),
			.coord (coord_v[a]),
			.lower (lower_q[a]),
			.upper (upper_q[a]),
			.num   (rem_c[a][0]),
			.den   (den_c[a][0]),
			.flags (fl_c[a][0])
		);
		assign quo_c[a][0] = '0;

		for (genvar i = 0; i < COORD_BITS; i++) begin : g_step
			mcq_div_step #(.COORD_BITS(COORD_BITS), .K(COORD_BITS-1-i)) u_step (
				.clk       (clk),
				.en        (en),
				.rem_in    (rem_c[a][i]),
				.den_in    (den_c[a][i]),
				.quo_in    (quo_c[a][i]),
				.flags_in  (fl_c[a][i]),
				.rem_out   (rem_c[a][i+1]),
				.den_out   (den_c[a][i+1]),
				.quo_out   (quo_c[a][i+1]),
				.flags_out (fl_c[a][i+1])
			);
		end

		assign axis_val[a] = fl_c[a][COORD_BITS].force_zero ? '0
			: fl_c[a][COORD_BITS].force_max ? '1 : quo_c[a][COORD_BITS];
	end

	always_comb begin
		code_c = '0;
		for (int j = 0; j < COORD_BITS; j++) begin
			code_c[3*j]   = axis_val[0][j];
			code_c[3*j+1] = axis_val[1][j];
			code_c[3*j+2] = axis_val[2][j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ch.ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= new_item;
			end
		end else if (new_item) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ch.ready) begin
			if (skid_vld_q) out_q <= skid_q;
			else if (new_item) out_q <= code_c;
		end else if (new_item) begin
			skid_q <= code_c;
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.zcode = out_q;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("buffered item without a presented item");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ch.ready))
		else $error("buffer filled while output was free");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAT-1] |-> !(fl_c[0][COORD_BITS].force_zero && fl_c[0][COORD_BITS].force_max))
		else $error("axis forced to zero and to max at once");
`endif

endmodule
